@@ design/cantr_pkg.sv @@
// ----------------------------------------------------------------------------
// cantr_pkg
// Shared constants and types for the CAN transfer reassembly block.
// ----------------------------------------------------------------------------
package cantr_pkg;

    localparam int STORE_BYTES_DEF = 64;
    localparam int FRAME_BYTES     = 8;
    // only the head of the store feeds the decoded record
    localparam int READ_BYTES      = 16;
    localparam int HALF_COUNT      = 7;

    typedef logic [READ_BYTES-1:0][7:0] head_bytes_t;

    typedef struct packed {
        logic last;
        logic seq_error;
    } frame_status_t;

endpackage

@@ design/cantr_assemble.sv @@
// ----------------------------------------------------------------------------
// cantr_assemble
// Tail-byte sequencing, fill count and the head of the byte store.
// ----------------------------------------------------------------------------
module cantr_assemble #(
    parameter int STORE_BYTES = cantr_pkg::STORE_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [2:0]                len_m1,
    input  logic [63:0]               bytes,
    output cantr_pkg::head_bytes_t    head_next,
    output cantr_pkg::frame_status_t  status
);

    localparam int FW         = $clog2(STORE_BYTES + 1);
    localparam int START_BIT  = 7;
    localparam int END_BIT    = 6;
    localparam int TOGGLE_BIT = 5;

    logic [FW-1:0]          fill_reg, fill_next;
    logic                   idle_reg, idle_next;
    logic                   error_reg, error_next;
    logic                   toggle_reg, toggle_next;
    cantr_pkg::head_bytes_t head_reg;

    always_comb
    begin
        logic [7:0]  tail;
        logic [FW:0] offset;
        logic [FW:0] sum;
        logic [FW-1:0] fill_v;

        tail        = bytes[{len_m1, 3'b000} +: 8];
        idle_next   = idle_reg;
        error_next  = error_reg;
        toggle_next = toggle_reg;
        fill_v      = fill_reg;

        if (idle_reg)
        begin
            if (!tail[START_BIT])
            begin
                error_next = 1'b1;
            end
            else
            begin
                idle_next   = 1'b0;
                error_next  = 1'b0;
                toggle_next = 1'b0;
                fill_v      = '0;
            end
        end
        if (tail[TOGGLE_BIT] != toggle_next)
        begin
            error_next = 1'b1;
        end

        // payload byte i lands at store position fill + i
        for (int p = 0; p < cantr_pkg::READ_BYTES; p++)
        begin
            offset = (FW+1)'(p) - {1'b0, fill_v};
            if (!offset[FW] && (offset < {{(FW-2){1'b0}}, len_m1}))
            begin
                head_next[p] = bytes[{offset[2:0], 3'b000} +: 8];
            end
            else
            begin
                head_next[p] = head_reg[p];
            end
        end

        sum = {1'b0, fill_v} + {{(FW-2){1'b0}}, len_m1};
        if (sum > (FW+1)'(STORE_BYTES))
        begin
            fill_next = FW'(STORE_BYTES);
        end
        else
        begin
            fill_next = sum[FW-1:0];
        end
        toggle_next = !toggle_next;

        status.last      = tail[END_BIT];
        status.seq_error = error_next;

        if (tail[END_BIT])
        begin
            idle_next   = 1'b1;
            fill_next   = '0;
            error_next  = 1'b0;
            toggle_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            idle_reg   <= 1'b1;
            error_reg  <= 1'b0;
            toggle_reg <= 1'b0;
            head_reg   <= '0;
        end
        else if (fire)
        begin
            fill_reg   <= fill_next;
            idle_reg   <= idle_next;
            error_reg  <= error_next;
            toggle_reg <= toggle_next;
            head_reg   <= head_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(STORE_BYTES))
        else $error("fill count past store size");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status.last |=> idle_reg && (fill_reg == '0) && !error_reg && !toggle_reg)
        else $error("end of transfer did not return to idle");

endmodule

@@ design/cantr_decode.sv @@
// ----------------------------------------------------------------------------
// cantr_decode
// Checksum extraction and half-to-single widening of the record fields.
// ----------------------------------------------------------------------------
module cantr_decode (
    input  cantr_pkg::head_bytes_t                 head,
    output logic [15:0]                            checksum,
    output logic [cantr_pkg::HALF_COUNT-1:0][31:0] halves
);

    localparam logic [15:0] HALF_EXP_MASK = 16'h7C00;
    localparam logic [15:0] HALF_MAN_MASK = 16'h03FF;
    localparam logic [7:0]  SINGLE_BIAS   = 8'd127;
    localparam logic [7:0]  HALF_BIAS     = 8'd15;

    function automatic logic [31:0] widen(input logic [15:0] h);
        logic [4:0] e;
        logic [9:0] m;
        logic [9:0] mn;
        logic [3:0] pos;
        logic [3:0] shift;
        logic [7:0] e32;
        e     = 5'((h & HALF_EXP_MASK) >> 10);
        m     = 10'(h & HALF_MAN_MASK);
        pos   = '0;
        mn    = m;
        e32   = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (m[i])
            begin
                pos = 4'(i);
            end
        end
        shift = 4'd10 - pos;
        if (e == 5'h1F)
        begin
            e32 = 8'hFF;
        end
        else if (e == 5'd0)
        begin
            if (m != 10'd0)
            begin
                // subnormal: move the leading one out into the hidden bit
                mn  = m << shift;
                e32 = SINGLE_BIAS - HALF_BIAS + 8'd1 - {4'b0000, shift};
            end
        end
        else
        begin
            e32 = {3'b000, e} + SINGLE_BIAS - HALF_BIAS;
        end
        return {h[15], e32, mn, 13'd0};
    endfunction

    assign checksum = {head[1], head[0]};

    always_comb
    begin
        for (int i = 0; i < cantr_pkg::HALF_COUNT; i++)
        begin
            halves[i] = widen({head[2*i+3], head[2*i+2]});
        end
    end

endmodule

@@ design/can_transfer_reassembly_half_decode.sv @@
// ----------------------------------------------------------------------------
// can_transfer_reassembly_half_decode
// CAN multi-frame reassembly with half-float record decode.
// ----------------------------------------------------------------------------
// Frame channel: frame_valid/frame_ready carry one CAN frame per transaction
// (frame_length 1..8, values above 8 act as 8, zero-length frames are taken
// and dropped). The last byte is the tail byte with start/end/toggle flags.
// Result channel: result_valid/result_ready carry one decoded record for each
// frame whose tail has the end flag.
// Path: an accepted frame is held in the frame register; when it advances it is
// sequenced into the store, and an end frame's record is loaded into the result register at the same edge.
// Throughput: one frame per cycle unless an end frame waits for the result register;
// the store update and half decode are a single pass between the frame register and the result register.
// Reset clears the head of the byte store, the fill count and the sequencing
// flags; the block is idle and ready right after reset.
// While the receiver stalls, frames without the end flag keep flowing; an
// end frame waits in the frame register until the result register is free.
// ----------------------------------------------------------------------------
module can_transfer_reassembly_half_decode #(
    parameter int STORE_BYTES = cantr_pkg::STORE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  logic [3:0]  frame_length,
    input  logic [63:0] frame_bytes,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] checksum,
    output logic [31:0] temperature,
    output logic [31:0] voltage,
    output logic [31:0] current,
    output logic [31:0] average_power,
    output logic [31:0] remaining_energy,
    output logic [31:0] full_energy,
    output logic [31:0] hours_to_full,
    output logic        sequence_error
);

    logic        in_valid_reg;
    logic [2:0]  len_m1_reg;
    logic [63:0] bytes_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        fire;

    cantr_pkg::head_bytes_t   head_next;
    cantr_pkg::frame_status_t status;

    logic [15:0]                            checksum_dec;
    logic [cantr_pkg::HALF_COUNT-1:0][31:0] halves_dec;
    logic [15:0]                            checksum_reg;
    logic [cantr_pkg::HALF_COUNT-1:0][31:0] halves_reg;
    logic                                   seq_error_reg;

    assign advance     = in_valid_reg && (!status.last || !out_valid_reg || result_ready);
    assign fire        = advance;
    assign frame_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame_ready)
        begin
            in_valid_reg <= frame_valid && (frame_length != 4'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
        begin
            len_m1_reg <= (frame_length >= 4'(cantr_pkg::FRAME_BYTES)) ?
                          3'(cantr_pkg::FRAME_BYTES - 1) : 3'(frame_length - 4'd1);
            bytes_reg  <= frame_bytes;
        end
    end

    cantr_assemble #(
        .STORE_BYTES (STORE_BYTES)
    ) u_assemble (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .len_m1    (len_m1_reg),
        .bytes     (bytes_reg),
        .head_next (head_next),
        .status    (status)
    );

    cantr_decode u_decode (
        .head     (head_next),
        .checksum (checksum_dec),
        .halves   (halves_dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && status.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && status.last)
        begin
            checksum_reg  <= checksum_dec;
            halves_reg    <= halves_dec;
            seq_error_reg <= status.seq_error;
        end
    end

    assign result_valid     = out_valid_reg;
    assign checksum         = checksum_reg;
    assign temperature      = halves_reg[0];
    assign voltage          = halves_reg[1];
    assign current          = halves_reg[2];
    assign average_power    = halves_reg[3];
    assign remaining_energy = halves_reg[4];
    assign full_energy      = halves_reg[5];
    assign hours_to_full    = halves_reg[6];
    assign sequence_error   = seq_error_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status.last |-> !out_valid_reg || result_ready)
        else $error("pending record overwritten");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> frame_ready)
        else $error("empty frame register not ready");

    a_nonend_flows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !status.last |-> frame_ready)
        else $error("frame without end flag stalled");

    a_record_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status.last |=> result_valid)
        else $error("end frame produced no record");

endmodule

@@ verif/can_transfer_reassembly_half_decode_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_transfer_reassembly_half_decode_test
// Self-checking bench for CAN transfer reassembly with half-float decode.
// A directed frame list covers the flag cases, the half-float corner values,
// long frames and a store overflow. Random transfers follow, mostly well
// formed with some broken ones and stray frames. A shadow copy of the byte
// store and sequencing flags predicts the records (zero-store rows carry their
// own); each is checked field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module can_transfer_reassembly_half_decode_test;

    localparam int          STORE_BYTES   = cantr_pkg::STORE_BYTES_DEF;
    localparam logic [7:0]  START_FLAG    = 8'h80;
    localparam logic [7:0]  END_FLAG      = 8'h40;
    localparam logic [7:0]  TOGGLE_FLAG   = 8'h20;
    localparam logic [7:0]  TAIL_LOW_MASK = 8'h1F;
    localparam int          RANDOM_FRAMES = 1180;
    localparam int          PHASE_FRAMES  = 150;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [15:0]                           checksum;
        logic [cantr_pkg::HALF_COUNT-1:0][31:0] halves;
        logic                                  sequence_error;
    } battery_record_t;

    typedef struct {
        logic [3:0]      len;
        logic [63:0]     data;
        bit              typed;
        battery_record_t want;
    } frame_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_ready;
    logic [3:0]  frame_length = 4'd0;
    logic [63:0] frame_bytes = 64'd0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [15:0] checksum;
    logic [31:0] temperature;
    logic [31:0] voltage;
    logic [31:0] current;
    logic [31:0] average_power;
    logic [31:0] remaining_energy;
    logic [31:0] full_energy;
    logic [31:0] hours_to_full;
    logic        sequence_error;

    // shadow state of the block
    logic [7:0] shadow_store [STORE_BYTES];
    int         shadow_fill;
    bit         shadow_idle;
    bit         shadow_error;
    bit         shadow_toggle;

    battery_record_t pending_records [$];
    frame_row_t      directed_rows [$];

    bit    steady = 1'b0;
    int    stall_left = 0;
    int    cycle_count = 0;
    int    fault_count = 0;
    int    frames_sent = 0;
    int    records_checked = 0;
    int    error_records = 0;
    int    bytes_dropped = 0;
    string half_names [cantr_pkg::HALF_COUNT] = '{"temperature", "voltage", "current",
        "average_power", "remaining_energy", "full_energy", "hours_to_full"};

    can_transfer_reassembly_half_decode #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_valid     (frame_valid),
        .frame_ready     (frame_ready),
        .frame_length    (frame_length),
        .frame_bytes     (frame_bytes),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .checksum        (checksum),
        .temperature     (temperature),
        .voltage         (voltage),
        .current         (current),
        .average_power   (average_power),
        .remaining_energy(remaining_energy),
        .full_energy     (full_energy),
        .hours_to_full   (hours_to_full),
        .sequence_error  (sequence_error)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  hexp;
        logic [10:0] man;
        logic [7:0]  sexp;
        int          shift;
        hexp  = h[14:10];
        man   = {1'b0, h[9:0]};
        shift = 0;
        if (hexp == 5'h1F)
            sexp = 8'hFF;
        else if (hexp != 5'd0)
            sexp = 8'(hexp + 112);
        else if (man == 11'd0)
            sexp = 8'd0;
        else
        begin
            // subnormal: bring the leading one up to the hidden bit
            while (!man[10])
            begin
                man = man << 1;
                shift++;
            end
            sexp = 8'(113 - shift);
        end
        return {h[15], sexp, man[9:0], 13'd0};
    endfunction

    // Takes one frame into the shadow state; returns 1 when it ends a transfer.
    function automatic bit absorb_frame(input logic [3:0] len, input logic [63:0] data,
                                        output battery_record_t rec);
        int         eff;
        logic [7:0] tail;
        bit         tog;
        rec = '0;
        if (len == 4'd0)
            return 1'b0;
        eff  = (len > cantr_pkg::FRAME_BYTES) ? cantr_pkg::FRAME_BYTES : int'(len);
        tail = data[8*(eff-1) +: 8];
        tog  = (tail & TOGGLE_FLAG) != 8'd0;
        if (shadow_idle)
        begin
            if ((tail & START_FLAG) == 8'd0)
                shadow_error = 1'b1;
            else
            begin
                shadow_idle   = 1'b0;
                shadow_error  = 1'b0;
                shadow_toggle = 1'b0;
                shadow_fill   = 0;
            end
        end
        if (tog != shadow_toggle)
            shadow_error = 1'b1;
        for (int i = 0; i < eff - 1; i++)
        begin
            if (shadow_fill < STORE_BYTES)
            begin
                shadow_store[shadow_fill] = data[8*i +: 8];
                shadow_fill++;
            end
            else
                bytes_dropped++;
        end
        shadow_toggle = !shadow_toggle;
        if ((tail & END_FLAG) == 8'd0)
            return 1'b0;
        rec.checksum = {shadow_store[1], shadow_store[0]};
        for (int k = 0; k < cantr_pkg::HALF_COUNT; k++)
            rec.halves[k] = widen_half({shadow_store[3+2*k], shadow_store[2+2*k]});
        rec.sequence_error = shadow_error;
        shadow_idle   = 1'b1;
        shadow_fill   = 0;
        shadow_error  = 1'b0;
        shadow_toggle = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [3:0] pick_length();
        if ($urandom_range(0, 99) < 92)
            return 4'($urandom_range(1, 8));
        return 4'($urandom_range(9, 15));
    endfunction

    function automatic logic [63:0] random_bytes();
        return {$urandom, $urandom};
    endfunction

    function automatic void add_row(input logic [3:0] len, input logic [63:0] data);
        frame_row_t row;
        row.len   = len;
        row.data  = data;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endfunction

    // Record read from an all-zero store: only the error flag can be set.
    function automatic void add_zero_store_row(input logic [63:0] data, input bit err);
        frame_row_t row;
        row.len   = 4'd1;
        row.data  = data;
        row.typed = 1'b1;
        row.want  = '0;
        row.want.sequence_error = err;
        directed_rows.push_back(row);
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("record %0d: %s expected %h, got %h",
                         records_checked, field, want, got);
        end
    endfunction

    task automatic send_frame(input logic [3:0] len, input logic [63:0] data,
                              input bit typed, input battery_record_t typed_rec);
        int              gap;
        bit              made;
        battery_record_t rec;
        gap = pick_gap();
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid  <= 1'b1;
        frame_length <= len;
        frame_bytes  <= data;
        @(posedge clk);
        while (!frame_ready)
            @(posedge clk);
        made = absorb_frame(len, data, rec);
        if (made)
            pending_records.push_back(typed ? typed_rec : rec);
        if (len != 4'd0)
            frames_sent++;
    endtask

    task automatic send_random_transfer();
        int          kind;
        int          nframes;
        int          broken;
        int          eff;
        logic [3:0]  len;
        logic [63:0] data;
        logic [7:0]  tail;
        kind = $urandom_range(0, 99);
        if (kind < 90)
        begin
            nframes = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                  : $urandom_range(1, 4);
            broken  = (kind >= 78) ? $urandom_range(0, nframes - 1) : -1;
            for (int f = 0; f < nframes; f++)
            begin
                if ($urandom_range(0, 29) == 0)
                    send_frame(4'd0, random_bytes(), 1'b0, '0);
                len  = pick_length();
                tail = 8'($urandom) & TAIL_LOW_MASK;
                if (f == 0)
                    tail |= START_FLAG;
                if (f == nframes - 1)
                    tail |= END_FLAG;
                if (f % 2 == 1)
                    tail |= TOGGLE_FLAG;
                if (f == broken)
                begin
                    case ($urandom_range(0, 2))
                        0:       tail ^= START_FLAG;
                        1:       tail ^= END_FLAG;
                        default: tail ^= TOGGLE_FLAG;
                    endcase
                end
                eff  = (len > cantr_pkg::FRAME_BYTES) ? cantr_pkg::FRAME_BYTES : int'(len);
                data = random_bytes();
                data[8*(eff-1) +: 8] = tail;
                send_frame(len, data, 1'b0, '0);
            end
        end
        else
        begin
            // stray frame with arbitrary length and tail
            send_frame(4'($urandom_range(0, 15)), random_bytes(), 1'b0, '0);
        end
    endtask

    // result side: random stalls, with steady stretches
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        battery_record_t got;
        battery_record_t want;
        if (rst_n && result_valid && result_ready)
        begin
            got.checksum       = checksum;
            got.halves[0]      = temperature;
            got.halves[1]      = voltage;
            got.halves[2]      = current;
            got.halves[3]      = average_power;
            got.halves[4]      = remaining_energy;
            got.halves[5]      = full_energy;
            got.halves[6]      = hours_to_full;
            got.sequence_error = sequence_error;
            if (pending_records.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("record with no frame to account for it: %h", got);
            end
            else
            begin
                want = pending_records.pop_front();
                compare_field("checksum", 32'(want.checksum), 32'(got.checksum));
                for (int k = 0; k < cantr_pkg::HALF_COUNT; k++)
                    compare_field(half_names[k], want.halves[k], got.halves[k]);
                compare_field("sequence_error", 32'(want.sequence_error),
                              32'(got.sequence_error));
                if (want.sequence_error)
                    error_records++;
            end
            records_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d records outstanding", pending_records.size());
            $display("can_transfer_reassembly_half_decode_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int last_phase;
        int directed_count;
        int drain_point;
        bit drained;
        last_phase = 0;
        drained    = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++)
            shadow_store[i] = 8'd0;
        shadow_fill   = 0;
        shadow_idle   = 1'b1;
        shadow_error  = 1'b0;
        shadow_toggle = 1'b0;

        // single-frame transfers on the cleared store
        add_zero_store_row(64'h00000000_000000C0, 1'b0);
        add_zero_store_row(64'h00000000_00000040, 1'b1);    // missing start
        add_zero_store_row(64'h00000000_000000E0, 1'b1);    // wrong toggle
        add_row(4'd0, 64'hFFFFFFFF_FFFFFFFF);               // zero length, dropped
        // three-frame transfer: half-float corners (-0, subnormals, inf, NaN, max)
        add_row(4'd8, 64'h80FF0001_8000FFFF);
        add_row(4'd8, 64'h207E01FC_007C0003);
        add_row(4'd3, 64'hA5A5A5A5_A5407BFF);
        // length above eight acts as eight
        add_row(4'd15, 64'hC0112233_44556677);
        // 70 payload bytes: the tail end falls off the store
        for (int f = 0; f < 10; f++)
            add_row(4'd8, {(f == 0 ? START_FLAG : 8'd0) | (f == 9 ? END_FLAG : 8'd0) |
                           (f % 2 == 1 ? TOGGLE_FLAG : 8'd0),
                           (f % 2 == 1 ? 56'h55AA55AA55AA55 : 56'hAA55AA55AA55AA) ^ 56'(f)});
        // no start while idle, then an end without start
        add_row(4'd2, 64'h00000000_0000005A);
        add_row(4'd2, 64'h00000000_000060A5);
        // start flag in the middle of a transfer
        add_row(4'd1, 64'h00000000_00000080);
        add_row(4'd1, 64'h00000000_000000A0);
        add_row(4'd1, 64'h00000000_00000040);
        add_row(4'd8, 64'hFFFFFFFF_FFFFFFFF);
        directed_count = directed_rows.size();
        drain_point    = directed_count + RANDOM_FRAMES / 2;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_frame(directed_rows[i].len, directed_rows[i].data,
                       directed_rows[i].typed, directed_rows[i].want);

        while (frames_sent < directed_count + RANDOM_FRAMES)
        begin
            if (!drained && frames_sent >= drain_point)
            begin
                // hold the frame side until every record is out
                frame_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_records.size() != 0);
                drained = 1'b1;
            end
            if (frames_sent / PHASE_FRAMES != last_phase)
            begin
                last_phase = frames_sent / PHASE_FRAMES;
                steady <= ($urandom_range(0, 3) == 0);
            end
            send_random_transfer();
        end
        frame_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_records.size() != 0);
        repeat (8) @(posedge clk);

        $display("covered %0d frames (%0d directed) and %0d records, %0d of them flagged",
                 frames_sent, directed_count, records_checked, error_records);
        $display("with %0d payload bytes dropped at the store end, %0d faults",
                 bytes_dropped, fault_count);
        if (fault_count == 0)
            $display("can_transfer_reassembly_half_decode_test: done, clean");
        else
            $display("can_transfer_reassembly_half_decode_test: done, errors");
        $finish;
    end

endmodule
